[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define ASSERT_IMPLY(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

// condition must hold in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

[design/spav_pkg.sv]
package spav_pkg;

    // spatial dimensions used (1 or 2)
    localparam int DIMENSIONS = 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUADRATIC = 8'd1;

    // 2.5 in Q16.16
    localparam logic [30:0] COEF_RESET = 31'd163840;
    // 0.01 in Q16.16
    localparam logic [9:0]  EPS_Q16    = 10'd655;
    localparam logic [30:0] Q_MAX      = '1;

    // restoring steps after the overflow check
    localparam int DIV_STEPS = 31;

    typedef struct packed {
        logic signed [31:0] vel_diff_x;
        logic signed [31:0] vel_diff_y;
        logic signed [31:0] pos_diff_x;
        logic signed [31:0] pos_diff_y;
        logic [30:0]        smoothing_sum;
        logic [30:0]        sound_speed_sum;
        logic [30:0]        density_sum;
        logic [30:0]        mass_first;
        logic [30:0]        mass_second;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
    } pair_t;

    // values carried alongside the arithmetic
    typedef struct packed {
        logic               appr;
        logic               zero_num;
        logic [29:0]        h;
        logic [30:0]        acq;
        logic [30:0]        rsum;
        logic [30:0]        mi;
        logic [30:0]        mj;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] dvx;
        logic signed [31:0] dvy;
    } ctx_t;

    typedef struct packed {
        logic signed [31:0] accel_first_x;
        logic signed [31:0] accel_first_y;
        logic signed [31:0] accel_second_x;
        logic signed [31:0] accel_second_y;
        logic signed [31:0] energy_rate_first;
        logic signed [31:0] energy_rate_second;
        logic               approaching;
    } result_t;

    // saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647)
            r = 32'sh7fff_ffff;
        else if (x < -66'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

[design/spav_if.sv]
interface spav_pair_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vel_diff_x;
    logic signed [31:0] vel_diff_y;
    logic signed [31:0] pos_diff_x;
    logic signed [31:0] pos_diff_y;
    logic [30:0]        smoothing_sum;
    logic [30:0]        sound_speed_sum;
    logic [30:0]        density_sum;
    logic [30:0]        mass_first;
    logic [30:0]        mass_second;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;

    modport source (output valid, vel_diff_x, vel_diff_y, pos_diff_x, pos_diff_y,
                    smoothing_sum, sound_speed_sum, density_sum, mass_first,
                    mass_second, grad_x, grad_y, input ready);
    modport sink (input valid, vel_diff_x, vel_diff_y, pos_diff_x, pos_diff_y,
                  smoothing_sum, sound_speed_sum, density_sum, mass_first,
                  mass_second, grad_x, grad_y, output ready);
endinterface

interface spav_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] accel_first_x;
    logic signed [31:0] accel_first_y;
    logic signed [31:0] accel_second_x;
    logic signed [31:0] accel_second_y;
    logic signed [31:0] energy_rate_first;
    logic signed [31:0] energy_rate_second;
    logic               approaching;

    modport source (output valid, accel_first_x, accel_first_y, accel_second_x,
                    accel_second_y, energy_rate_first, energy_rate_second,
                    approaching, input ready);
    modport sink (input valid, accel_first_x, accel_first_y, accel_second_x,
                  accel_second_y, energy_rate_first, energy_rate_second,
                  approaching, output ready);
endinterface

interface spav_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/sph_pair_artificial_viscosity.sv]
// channel  | dir | payload
// pair     | in  | velocity, position, smoothing, sound speed, density, masses, gradient
// result   | out | accelerations of both particles, energy rates, approaching flag
// cfg      | in  | index (0 alpha, 1 beta) and 32-bit data, always ready
//
// one pair per cycle while no result is held at the output
// the pipeline is two 32-stage restoring dividers plus 13 arithmetic stages
// reset clears all valid bits and loads alpha and beta with 2.5
// a held result freezes the whole pipeline; pair.ready then drops
`include "assert_macros.svh"

module sph_pair_artificial_viscosity (
    input  logic          clk,
    input  logic          rst_n,
    spav_pair_if.sink     pair,
    spav_result_if.source result,
    spav_cfg_if.sink      cfg
);
    import spav_pkg::*;

    logic [30:0] lin_reg, quad_reg;
    logic        en;
    pair_t       in_pair;

    logic        fr_valid;
    logic [63:0] fr_num;
    logic [47:0] fr_den;
    ctx_t        fr_ctx;

    logic        da_valid, da_sat;
    logic [30:0] da_quo;
    ctx_t        da_ctx;

    logic        md_valid;
    logic [63:0] md_num;
    logic [47:0] md_den;
    ctx_t        md_ctx;

    logic        db_valid, db_sat;
    logic [30:0] db_quo;
    ctx_t        db_ctx;

    logic        bk_valid;
    result_t     bk_res;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_reg  <= COEF_RESET;
            quad_reg <= COEF_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_LINEAR:    lin_reg  <= cfg.data[30:0];
                REG_QUADRATIC: quad_reg <= cfg.data[30:0];
                default:       ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // global advance: stall only while a result waits
    assign en         = !bk_valid || result.ready;
    assign pair.ready = en;

    always_comb
    begin
        in_pair.vel_diff_x      = pair.vel_diff_x;
        in_pair.vel_diff_y      = pair.vel_diff_y;
        in_pair.pos_diff_x      = pair.pos_diff_x;
        in_pair.pos_diff_y      = pair.pos_diff_y;
        in_pair.smoothing_sum   = pair.smoothing_sum;
        in_pair.sound_speed_sum = pair.sound_speed_sum;
        in_pair.density_sum     = pair.density_sum;
        in_pair.mass_first      = pair.mass_first;
        in_pair.mass_second     = pair.mass_second;
        in_pair.grad_x          = pair.grad_x;
        in_pair.grad_y          = pair.grad_y;
    end

    spav_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pair.valid),
        .in_pair   (in_pair),
        .alpha     (lin_reg),
        .out_valid (fr_valid),
        .div_num   (fr_num),
        .div_den   (fr_den),
        .out_ctx   (fr_ctx)
    );

    // velocity ratio division
    spav_div u_div_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .num       (fr_num),
        .den       (fr_den),
        .in_ctx    (fr_ctx),
        .out_valid (da_valid),
        .quo       (da_quo),
        .sat       (da_sat),
        .out_ctx   (da_ctx)
    );

    spav_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (da_valid),
        .quo       (da_quo),
        .sat       (da_sat),
        .in_ctx    (da_ctx),
        .beta      (quad_reg),
        .out_valid (md_valid),
        .div_num   (md_num),
        .div_den   (md_den),
        .out_ctx   (md_ctx)
    );

    // division by density sum
    spav_div u_div_density (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (md_valid),
        .num       (md_num),
        .den       (md_den),
        .in_ctx    (md_ctx),
        .out_valid (db_valid),
        .quo       (db_quo),
        .sat       (db_sat),
        .out_ctx   (db_ctx)
    );

    spav_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (db_valid),
        .quo       (db_quo),
        .sat       (db_sat),
        .in_ctx    (db_ctx),
        .out_valid (bk_valid),
        .out_res   (bk_res)
    );

    assign result.valid              = bk_valid;
    assign result.accel_first_x      = bk_res.accel_first_x;
    assign result.accel_first_y      = bk_res.accel_first_y;
    assign result.accel_second_x     = bk_res.accel_second_x;
    assign result.accel_second_y     = bk_res.accel_second_y;
    assign result.energy_rate_first  = bk_res.energy_rate_first;
    assign result.energy_rate_second = bk_res.energy_rate_second;
    assign result.approaching        = bk_res.approaching;

    // checks
    `ASSERT_IMPLY(a_separating_zero, clk, rst_n, result.valid && !result.approaching, result.accel_first_x == '0 && result.accel_first_y == '0 && result.accel_second_x == '0 && result.accel_second_y == '0 && result.energy_rate_first == '0 && result.energy_rate_second == '0)
    `ASSERT_IMPLY(a_stall_cause, clk, rst_n, !pair.ready, result.valid && !result.ready)
    `ASSERT_NEXT(a_cfg_linear, clk, rst_n, cfg.valid && cfg.index == REG_LINEAR, lin_reg == $past(cfg.data[30:0]))

endmodule

[design/spav_div.sv]
module spav_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [63:0]     num,
    input  logic [47:0]     den,
    input  spav_pkg::ctx_t  in_ctx,
    output logic            out_valid,
    output logic [30:0]     quo,
    output logic            sat,
    output spav_pkg::ctx_t  out_ctx
);
    import spav_pkg::*;

    logic              vld_reg [0:DIV_STEPS];
    logic [47:0]       rem_reg [0:DIV_STEPS];
    logic [30:0]       low_reg [0:DIV_STEPS];
    logic [30:0]       q_reg   [0:DIV_STEPS];
    logic [47:0]       den_reg [0:DIV_STEPS];
    logic              sat_reg [0:DIV_STEPS];
    ctx_t              ctx_reg [0:DIV_STEPS];

    // entry: overflow check, quotient of 2^31 or more saturates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= 48'(num[63:31]);
            low_reg[0] <= num[30:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
            sat_reg[0] <= (48'(num[63:31]) >= den);
            ctx_reg[0] <= in_ctx;
        end
    end

    // one restoring step per stage
    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_step
        logic [48:0] trial;
        logic        ge;
        logic [47:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k-1], low_reg[k-1][30]};
            ge       = (trial >= 49'(den_reg[k-1]));
            rem_next = ge ? 48'(trial - 49'(den_reg[k-1])) : trial[47:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= {low_reg[k-1][29:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][29:0], ge};
                den_reg[k] <= den_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS];
    assign quo       = q_reg[DIV_STEPS];
    assign sat       = sat_reg[DIV_STEPS];
    assign out_ctx   = ctx_reg[DIV_STEPS];

endmodule

[design/spav_front.sv]
module spav_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  spav_pkg::pair_t in_pair,
    input  logic [30:0]     alpha,
    output logic            out_valid,
    output logic [63:0]     div_num,
    output logic [47:0]     div_den,
    output spav_pkg::ctx_t  out_ctx
);
    import spav_pkg::*;

    logic signed [31:0] dvx, dvy, drx, dry, gy;
    logic [29:0]        h, c;
    ctx_t               s1_ctx_next;

    logic               s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic signed [63:0] s1_p0_reg, s1_p1_reg, s1_q0_reg, s1_q1_reg;
    logic [59:0]        s1_hh_reg;
    logic [60:0]        s1_ac_reg;
    ctx_t               s1_ctx_reg, s2_ctx_reg, s3_ctx_reg;

    logic signed [64:0] dot;
    logic signed [48:0] s2_vr_next, s2_vr_reg;
    logic [47:0]        s2_r2_next, s2_r2_reg;
    logic [53:0]        s2_eps_next, s2_eps_reg;
    logic [30:0]        s2_acq_next;
    ctx_t               s2_ctx_next;

    logic [47:0]        den_sum, s3_den_next, s3_den_reg;
    logic signed [48:0] neg_vr;
    logic [63:0]        s3_num_next, s3_num_reg;

    // stage 1: products
    always_comb
    begin
        dvx = in_pair.vel_diff_x;
        drx = in_pair.pos_diff_x;
        dvy = (DIMENSIONS > 1) ? in_pair.vel_diff_y : '0;
        dry = (DIMENSIONS > 1) ? in_pair.pos_diff_y : '0;
        gy  = (DIMENSIONS > 1) ? in_pair.grad_y : '0;
        h   = in_pair.smoothing_sum[30:1];
        c   = in_pair.sound_speed_sum[30:1];
        s1_ctx_next          = '0;
        s1_ctx_next.h        = h;
        s1_ctx_next.rsum     = in_pair.density_sum;
        s1_ctx_next.mi       = in_pair.mass_first;
        s1_ctx_next.mj       = in_pair.mass_second;
        s1_ctx_next.gx       = in_pair.grad_x;
        s1_ctx_next.gy       = gy;
        s1_ctx_next.dvx      = dvx;
        s1_ctx_next.dvy      = dvy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_p0_reg  <= 64'(dvx) * 64'(drx);
            s1_p1_reg  <= 64'(dvy) * 64'(dry);
            s1_q0_reg  <= 64'(drx) * 64'(drx);
            s1_q1_reg  <= 64'(dry) * 64'(dry);
            s1_hh_reg  <= 60'(h) * 60'(h);
            s1_ac_reg  <= 61'(alpha) * 61'(c);
            s1_ctx_reg <= s1_ctx_next;
        end
    end

    // stage 2: sign of dot product, sums, eps product, capped alpha * c
    always_comb
    begin
        dot         = 65'(s1_p0_reg) + 65'(s1_p1_reg);
        s2_vr_next  = 49'($signed(s1_p0_reg[63:16])) + 49'($signed(s1_p1_reg[63:16]));
        s2_r2_next  = 48'(s1_q0_reg[63:16]) + 48'(s1_q1_reg[63:16]);
        s2_eps_next = 54'(s1_hh_reg[59:16]) * 54'(EPS_Q16);
        s2_acq_next = (s1_ac_reg[60:16] > 45'(Q_MAX)) ? Q_MAX : s1_ac_reg[46:16];
        s2_ctx_next      = s1_ctx_reg;
        s2_ctx_next.appr = dot[64];
        s2_ctx_next.acq  = s2_acq_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_vr_reg  <= s2_vr_next;
            s2_r2_reg  <= s2_r2_next;
            s2_eps_reg <= s2_eps_next;
            s2_ctx_reg <= s2_ctx_next;
        end
    end

    // stage 3: denominator and divider numerator
    always_comb
    begin
        den_sum     = s2_r2_reg + 48'(s2_eps_reg[53:16]);
        s3_den_next = (den_sum == '0) ? 48'd1 : den_sum;
        neg_vr      = -s2_vr_reg;
        s3_num_next = {neg_vr[47:0], 16'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_den_reg <= s3_den_next;
            s3_num_reg <= s3_num_next;
            s3_ctx_reg <= s2_ctx_reg;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    assign out_valid = s3_vld_reg;
    assign div_num   = s3_num_reg;
    assign div_den   = s3_den_reg;
    assign out_ctx   = s3_ctx_reg;

endmodule

[design/spav_mid.sv]
module spav_mid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [30:0]     quo,
    input  logic            sat,
    input  spav_pkg::ctx_t  in_ctx,
    input  logic [30:0]     beta,
    output logic            out_valid,
    output logic [63:0]     div_num,
    output logic [47:0]     div_den,
    output spav_pkg::ctx_t  out_ctx
);
    import spav_pkg::*;

    logic               m1_vld_reg, m2_vld_reg, m3_vld_reg, m4_vld_reg, m5_vld_reg;
    ctx_t               m1_ctx_reg, m2_ctx_reg, m3_ctx_reg, m4_ctx_reg, m5_ctx_reg;

    logic signed [31:0] t;
    logic signed [63:0] m1_phip_reg;
    logic signed [31:0] m2_phi_next, m2_phi_reg;
    logic signed [32:0] neg_phi;
    logic signed [65:0] m3_n1p_reg;
    logic signed [63:0] m3_n2p_reg;
    logic signed [31:0] n1_full, n2_full;
    logic [30:0]        m4_n1_reg;
    logic [61:0]        m4_bp_reg;
    logic [30:0]        b;
    logic [31:0]        sum;
    logic [30:0]        m5_num_next, m5_num_reg;
    ctx_t               m5_ctx_next;

    // stage 1: phi product h * t
    always_comb
    begin
        t = sat ? 32'sh8000_0000 : -$signed({1'b0, quo});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_phip_reg <= 64'($signed({2'b0, in_ctx.h})) * 64'(t);
            m1_ctx_reg  <= in_ctx;
        end
    end

    // stage 2: phi
    always_comb
    begin
        m2_phi_next = sat32(66'(m1_phip_reg >>> 16));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_phi_reg <= m2_phi_next;
            m2_ctx_reg <= m1_ctx_reg;
        end
    end

    // stage 3: linear and quadratic products
    always_comb
    begin
        neg_phi = -33'(m2_phi_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_n1p_reg <= 66'($signed({1'b0, m2_ctx_reg.acq})) * 66'(neg_phi);
            m3_n2p_reg <= 64'(m2_phi_reg) * 64'(m2_phi_reg);
            m3_ctx_reg <= m2_ctx_reg;
        end
    end

    // stage 4: beta times phi squared
    always_comb
    begin
        n1_full = sat32(66'(m3_n1p_reg >>> 16));
        n2_full = sat32(66'(m3_n2p_reg >>> 16));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m4_n1_reg  <= n1_full[30:0];
            m4_bp_reg  <= 62'(beta) * 62'(n2_full[30:0]);
            m4_ctx_reg <= m3_ctx_reg;
        end
    end

    // stage 5: numerator, capped
    always_comb
    begin
        b           = (m4_bp_reg[61:16] > 46'(Q_MAX)) ? Q_MAX : m4_bp_reg[46:16];
        sum         = 32'(m4_n1_reg) + 32'(b);
        m5_num_next = (sum > 32'(Q_MAX)) ? Q_MAX : sum[30:0];
        m5_ctx_next          = m4_ctx_reg;
        m5_ctx_next.zero_num = (m5_num_next == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m5_num_reg <= m5_num_next;
            m5_ctx_reg <= m5_ctx_next;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            m4_vld_reg <= 1'b0;
            m5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_vld_reg <= in_valid;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            m4_vld_reg <= m3_vld_reg;
            m5_vld_reg <= m4_vld_reg;
        end
    end

    assign out_valid = m5_vld_reg;
    assign div_num   = {16'b0, m5_num_reg, 17'b0};
    assign div_den   = {17'b0, m5_ctx_reg.rsum};
    assign out_ctx   = m5_ctx_reg;

endmodule

[design/spav_back.sv]
module spav_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [30:0]       quo,
    input  logic              sat,
    input  spav_pkg::ctx_t    in_ctx,
    output logic              out_valid,
    output spav_pkg::result_t out_res
);
    import spav_pkg::*;

    logic               b1_vld_reg, b2_vld_reg, b3_vld_reg, b4_vld_reg, out_vld_reg;
    ctx_t               b1_ctx_reg, b2_ctx_reg, b3_ctx_reg, b4_ctx_reg;

    logic [30:0]        pi;
    logic signed [63:0] b1_gpx_reg, b1_gpy_reg;

    logic signed [31:0] gx, gy, mi_s, mj_s;
    logic signed [65:0] b2_a1x_reg, b2_a1y_reg;
    logic signed [63:0] b2_a2x_reg, b2_a2y_reg, b2_ex_reg, b2_ey_reg;

    logic signed [31:0] ex, ey, es_full;
    logic signed [31:0] b3_a1x_reg, b3_a1y_reg, b3_a2x_reg, b3_a2y_reg, b3_es_reg;

    logic signed [31:0] b4_a1x_reg, b4_a1y_reg, b4_a2x_reg, b4_a2y_reg;
    logic signed [63:0] b4_e1p_reg, b4_e2p_reg;

    result_t            out_next, out_reg;

    // stage 1: Pi times gradient
    always_comb
    begin
        if (in_ctx.zero_num)
            pi = '0;
        else if (sat)
            pi = Q_MAX;
        else
            pi = quo;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_gpx_reg <= 64'($signed({1'b0, pi})) * 64'(in_ctx.gx);
            b1_gpy_reg <= 64'($signed({1'b0, pi})) * 64'(in_ctx.gy);
            b1_ctx_reg <= in_ctx;
        end
    end

    // stage 2: mass and velocity products
    always_comb
    begin
        gx   = sat32(66'(b1_gpx_reg >>> 16));
        gy   = sat32(66'(b1_gpy_reg >>> 16));
        mi_s = $signed({1'b0, b1_ctx_reg.mi});
        mj_s = $signed({1'b0, b1_ctx_reg.mj});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2_a1x_reg <= 66'(-33'(gx)) * 66'(mj_s);
            b2_a1y_reg <= 66'(-33'(gy)) * 66'(mj_s);
            b2_a2x_reg <= 64'(gx) * 64'(mi_s);
            b2_a2y_reg <= 64'(gy) * 64'(mi_s);
            b2_ex_reg  <= 64'(gx) * 64'(b1_ctx_reg.dvx);
            b2_ey_reg  <= 64'(gy) * 64'(b1_ctx_reg.dvy);
            b2_ctx_reg <= b1_ctx_reg;
        end
    end

    // stage 3: accelerations and halved energy sum
    always_comb
    begin
        ex      = sat32(66'(b2_ex_reg >>> 16));
        ey      = sat32(66'(b2_ey_reg >>> 16));
        es_full = sat32(66'(33'(ex) + 33'(ey)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b3_a1x_reg <= sat32(66'(b2_a1x_reg >>> 16));
            b3_a1y_reg <= sat32(66'(b2_a1y_reg >>> 16));
            b3_a2x_reg <= sat32(66'(b2_a2x_reg >>> 16));
            b3_a2y_reg <= sat32(66'(b2_a2y_reg >>> 16));
            b3_es_reg  <= es_full >>> 1;
            b3_ctx_reg <= b2_ctx_reg;
        end
    end

    // stage 4: energy products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b4_a1x_reg <= b3_a1x_reg;
            b4_a1y_reg <= b3_a1y_reg;
            b4_a2x_reg <= b3_a2x_reg;
            b4_a2y_reg <= b3_a2y_reg;
            b4_e1p_reg <= 64'(b3_es_reg) * 64'($signed({1'b0, b3_ctx_reg.mj}));
            b4_e2p_reg <= 64'(b3_es_reg) * 64'($signed({1'b0, b3_ctx_reg.mi}));
            b4_ctx_reg <= b3_ctx_reg;
        end
    end

    // output register, all zero for a separating pair
    always_comb
    begin
        out_next = '0;
        if (b4_ctx_reg.appr)
        begin
            out_next.accel_first_x      = b4_a1x_reg;
            out_next.accel_first_y      = b4_a1y_reg;
            out_next.accel_second_x     = b4_a2x_reg;
            out_next.accel_second_y     = b4_a2y_reg;
            out_next.energy_rate_first  = sat32(66'(b4_e1p_reg >>> 16));
            out_next.energy_rate_second = sat32(66'(b4_e2p_reg >>> 16));
            out_next.approaching        = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg  <= 1'b0;
            b2_vld_reg  <= 1'b0;
            b3_vld_reg  <= 1'b0;
            b4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_vld_reg  <= in_valid;
            b2_vld_reg  <= b1_vld_reg;
            b3_vld_reg  <= b2_vld_reg;
            b4_vld_reg  <= b3_vld_reg;
            out_vld_reg <= b4_vld_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_res   = out_reg;

endmodule
